FILE: src/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the substring replace unit
// Holds sizes, register indexes, sequencer states and the result layout.
// ----------------------------------------------------------------------------
package ssr_pkg;

   // sizes
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 4;
   localparam int TEXT_W          = MAX_PATTERN * BYTE_W;
   localparam int REPL_W          = MAX_REPLACEMENT * BYTE_W;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int REPL_IDX_W      = $clog2(MAX_REPLACEMENT);
   localparam int HELD_IDX_W      = $clog2(MAX_PATTERN);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH     = 2'd0,
      CSR_PATTERN_BYTES      = 2'd1,
      CSR_REPLACEMENT_LENGTH = 2'd2,
      CSR_REPLACEMENT_BYTES  = 2'd3
   } csr_index_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL,
      ST_FLUSH,
      ST_FIN
   } back_state_type;

   // one queued request
   typedef struct packed {
      logic              end_of_string;
      logic [BYTE_W-1:0] in_byte;
   } req_entry_type;

   // one result
   typedef struct packed {
      logic              string_done;
      logic              has_byte;
      logic [BYTE_W-1:0] out_byte;
   } rsp_entry_type;

   // clamp a written length field to its maximum
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] value,
                                                  input logic [LEN_W-1:0] limit);
      clamp_len = (value > limit) ? limit : value;
   endfunction

endpackage

FILE: src/ssr_queue.sv
// ----------------------------------------------------------------------------
// ssr_queue: front request queue
// Accepts request bytes from the stream port and buffers them for the back
// end, so that each side can stall independently.
// ----------------------------------------------------------------------------
module ssr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   input  logic                  req_tlast,   // end_of_string
   output logic                  head_valid,
   output ssr_pkg::req_entry_type head_entry,
   input  logic                  head_pop
);
   import ssr_pkg::*;

   req_entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        fill_ff, fill_in;
   logic                   push;
   logic                   pop;

   // handshake
   assign req_tready = (fill_ff != QUEUE_DEPTH[QPTR_W:0]);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (fill_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_entry = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{end_of_string: req_tlast, in_byte: req_tdata};
      end
   end

endmodule

FILE: src/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back: match and emit sequencer
// Holds candidate bytes, checks them against the pattern, emits released,
// replacement and flushed bytes one per cycle unless the output stalls,
// through a pending stage and an output register.
// ----------------------------------------------------------------------------
module ssr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  ssr_pkg::req_entry_type        head_entry,
   output logic                          head_pop,
   input  logic [ssr_pkg::LEN_W-1:0]     pattern_length,
   input  logic [ssr_pkg::TEXT_W-1:0]    pattern_bytes,
   input  logic [ssr_pkg::LEN_W-1:0]     replacement_length,
   input  logic [ssr_pkg::REPL_W-1:0]    replacement_bytes,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tuser,   // has_byte
   output logic                          rsp_tlast    // string_done
);
   import ssr_pkg::*;

   back_state_type          state_ff, state_in;
   logic [BYTE_W-1:0]       held_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]       held_in [MAX_PATTERN];
   logic [LEN_W-1:0]        count_ff, count_in;
   logic                    eos_ff, eos_in;
   logic [REPL_IDX_W-1:0]   idx_ff, idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   rsp_entry_type           pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_entry_type           out_ff, out_in;

   logic                    adv;
   logic                    can_emit;
   logic                    fin_ok;
   logic [MAX_PATTERN-1:0]  lane_ok;
   logic                    is_prefix;
   logic                    full_match;
   logic                    emit;
   rsp_entry_type           emit_res;
   logic                    finish;
   logic                    shift;

   // output side readiness
   assign adv      = !out_valid_ff || rsp_tready;
   assign can_emit = !pend_valid_ff || adv;
   assign fin_ok   = (!pend_valid_ff && !eos_ff) || adv;

   // prefix check over all held lanes
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         lane_ok[i] = (LEN_W'(i) >= count_ff) ||
                      (held_ff[i] == pattern_bytes[i*BYTE_W +: BYTE_W]);
      end
   end
   assign is_prefix  = (count_ff <= pattern_length) && (&lane_ok);
   assign full_match = is_prefix && (count_ff == pattern_length) && (count_ff != '0);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      eos_in   = eos_ff;
      idx_in   = idx_ff;
      head_pop = 1'b0;
      emit     = 1'b0;
      emit_res = '{string_done: 1'b0, has_byte: 1'b1, out_byte: held_ff[0]};
      finish   = 1'b0;
      shift    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               eos_in   = head_entry.end_of_string;
               count_in = count_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (count_ff != '0 && !is_prefix) begin
               // oldest byte cannot start a match: release it
               if (can_emit) begin
                  emit     = 1'b1;
                  shift    = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else if (full_match) begin
               count_in = '0;
               idx_in   = '0;
               if (replacement_length != '0) begin
                  state_in = ST_REPL;
               end
            end else if (eos_ff && count_ff != '0) begin
               state_in = ST_FLUSH;
            end else begin
               if (fin_ok) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPL: begin
            if (can_emit) begin
               emit     = 1'b1;
               emit_res = '{string_done: 1'b0, has_byte: 1'b1,
                            out_byte: replacement_bytes[idx_ff*BYTE_W +: BYTE_W]};
               idx_in   = idx_ff + 1'b1;
               if ({1'b0, idx_ff} == replacement_length - 1'b1) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               emit     = 1'b1;
               shift    = 1'b1;
               count_in = count_ff - 1'b1;
               if (count_ff == LEN_W'(1)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (fin_ok) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // held byte shift and append
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         held_in[i] = held_ff[i];
      end
      if (shift) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
      end else if (head_pop) begin
         held_in[count_ff[HELD_IDX_W-1:0]] = head_entry.in_byte;
      end
   end

   // pending stage and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      if (emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_res;
      end else if (finish) begin
         if (pend_valid_ff) begin
            out_valid_in        = 1'b1;
            out_in              = pend_ff;
            out_in.string_done  = eos_ff;
            pend_valid_in       = 1'b0;
         end else if (eos_ff) begin
            // no data byte for this string end: bare end mark
            out_valid_in = 1'b1;
            out_in       = '{string_done: 1'b1, has_byte: 1'b0, out_byte: '0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff  <= eos_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         held_ff[i] <= held_in[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tuser  = out_ff.has_byte;
   assign rsp_tlast  = out_ff.string_done;

`ifndef SYNTH
   // between requests nothing waits in the pending stage
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over after request");

   // a request never leaves a full window of held bytes
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff < LEN_W'(MAX_PATTERN)))
      else $error("held byte count out of range between requests");

   // replacement output only after the window was cleared
   a_repl_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPL) |-> (count_ff == '0))
      else $error("held bytes present during replacement");

   // flush runs only at string end with bytes to flush
   a_flush_eos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (eos_ff && count_ff != '0))
      else $error("flush without string end or held bytes");

   // a stalled result is not replaced
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result overwritten");
`endif

endmodule

FILE: src/stream_substring_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_substring_replace_unit: streaming substring replace
// Replaces each leftmost, non-overlapping pattern occurrence in a byte
// stream by a replacement text, with a flush at the end of every string.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one string byte per request, req_tlast on the last byte.
//   rsp_* carries result bytes; rsp_tuser high means rsp_tdata holds a byte,
//   rsp_tlast marks the final result of a string (a bare end mark with
//   rsp_tuser low is sent when the string end produces no byte).
//   csr_* writes pattern and replacement registers; write only while idle.
//   Lengths above eight are taken as eight; a pattern length of zero passes
//   bytes through unchanged.
// Flow:
//   The back sequencer loads a request, then scans it, releases, replaces
//   or flushes bytes, and after a replacement or flush takes a finish
//   step; it emits at most one result per cycle, and only while the output
//   can take it. A four-entry request queue keeps accepting while the back
//   end works.
// Reset empties the queue and clears the registers to zero. When the
// receiver stalls, the output register holds its result and the back end
// and then the queue fill up before req_tready drops.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // has_byte
   output logic        rsp_tlast,   // string_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0] csr_data
);
   import ssr_pkg::*;

   logic [LEN_W-1:0]   plen_ff;
   logic [TEXT_W-1:0]  pat_ff;
   logic [LEN_W-1:0]   rlen_ff;
   logic [REPL_W-1:0]  rep_ff;
   logic               csr_write;
   logic               head_valid;
   req_entry_type      head_entry;
   logic               head_pop;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         pat_ff  <= '0;
         rlen_ff <= '0;
         rep_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: begin
               plen_ff <= clamp_len(csr_data[LEN_W-1:0], LEN_W'(MAX_PATTERN));
            end
            CSR_PATTERN_BYTES: begin
               pat_ff <= csr_data[TEXT_W-1:0];
            end
            CSR_REPLACEMENT_LENGTH: begin
               rlen_ff <= clamp_len(csr_data[LEN_W-1:0], LEN_W'(MAX_REPLACEMENT));
            end
            CSR_REPLACEMENT_BYTES: begin
               rep_ff <= csr_data[REPL_W-1:0];
            end
            default: begin
               plen_ff <= plen_ff;
            end
         endcase
      end
   end

   // front queue
   ssr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   // back sequencer
   ssr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .head_pop           (head_pop),
      .pattern_length     (plen_ff),
      .pattern_bytes      (pat_ff),
      .replacement_length (rlen_ff),
      .replacement_bytes  (rep_ff),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .rsp_tlast          (rsp_tlast)
   );

endmodule

FILE: tb/stream_substring_replace_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_substring_replace_unit_tb: self-checking bench for substring replace
// Drives byte strings through the request stream and programs pattern and
// replacement registers between phases. A behavioral replace engine predicts
// most results, the directed table gives the others, and each response is
// checked in order, under several sender gap and receiver stall mixes.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit_tb;
   import ssr_pkg::*;

   localparam int SETTLE_CYCLES   = 32;
   localparam int STALL_LIMIT     = 4000;
   localparam int LONG_HOLD       = 250;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 38;
   localparam int PRESSURE_PHASE  = 4;
   localparam int PAUSE_PHASE     = 5;

   // one directed step: a register write or a string byte
   typedef struct packed {
      logic          is_reg;
      csr_index_type reg_idx;
      logic [63:0]   reg_val;
      logic [7:0]    in_byte;
      logic          eos;
      logic          typed;
      rsp_entry_type typed_rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] out_byte
   logic        rsp_tuser;           // has_byte
   logic        rsp_tlast;           // string_done
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PATTERN_LENGTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // replace engine state, mirrored from the programmed registers
   logic [LEN_W-1:0] pat_len = '0;
   logic [63:0]      pat_word = '0;
   logic [LEN_W-1:0] rep_len = '0;
   logic [63:0]      rep_word = '0;
   logic [7:0]       window_bytes [MAX_PATTERN] = '{default: 8'h00};
   int               window_fill = 0;

   rsp_entry_type step_out [$];
   rsp_entry_type edited_text_q [$];
   rsp_entry_type want_rsp;

   int failures      = 0;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;
   int quiet_cycles  = 0;

   stim_row_type directed_rows [$];

   stream_substring_replace_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // add one result to the current step
   function automatic void emit_byte(input logic [7:0] value, input logic has);
      rsp_entry_type r;
      r.string_done = 1'b0;
      r.has_byte    = has;
      r.out_byte    = value;
      step_out.push_back(r);
   endfunction

   // let go of the oldest held byte
   function automatic void release_front();
      emit_byte(window_bytes[0], 1'b1);
      for (int i = 1; i < window_fill; i++) window_bytes[i-1] = window_bytes[i];
      window_fill--;
   endfunction

   // results caused by one string byte
   function automatic void replace_step(input logic [7:0] value, input logic last);
      int plen;
      int rlen;
      bit prefix_ok;
      step_out.delete();
      plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      rlen = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
      if (window_fill >= MAX_PATTERN) release_front();
      window_bytes[window_fill] = value;
      window_fill++;
      // naive forward search: drop the oldest byte until the window is a prefix
      while (window_fill > 0) begin
         prefix_ok = (window_fill <= plen);
         for (int i = 0; i < window_fill; i++) begin
            if (window_bytes[i] != pat_word[8*i +: 8]) prefix_ok = 1'b0;
         end
         if (prefix_ok) begin
            if (window_fill == plen) begin
               for (int i = 0; i < rlen; i++) emit_byte(rep_word[8*i +: 8], 1'b1);
               window_fill = 0;
            end
            break;
         end
         release_front();
      end
      // end of string: flush, bare end mark when nothing came out
      if (last) begin
         for (int i = 0; i < window_fill; i++) emit_byte(window_bytes[i], 1'b1);
         window_fill = 0;
         if (step_out.size() == 0) emit_byte(8'h00, 1'b0);
         step_out[step_out.size()-1].string_done = 1'b1;
      end
   endfunction

   // offer one request, with random sender gaps, and record what it causes
   task automatic push_byte(input logic [7:0] value, input logic last,
                            input logic typed, input rsp_entry_type typed_rsp);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      replace_step(value, last);
      if (typed) begin
         edited_text_q.push_back(typed_rsp);
      end else begin
         foreach (step_out[i]) edited_text_q.push_back(step_out[i]);
      end
   endtask

   // register write; valid stays up so writes can go back to back
   task automatic write_register(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_LENGTH:     pat_len  = value[LEN_W-1:0];
         CSR_PATTERN_BYTES:      pat_word = value;
         CSR_REPLACEMENT_LENGTH: rep_len  = value[LEN_W-1:0];
         CSR_REPLACEMENT_BYTES:  rep_word = value;
      endcase
   endtask

   // stop sending, wait for every result, then let the back end go quiet
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (edited_text_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new pattern from a three-letter alphabet so matches overlap often
   task automatic program_pattern(input int plen, input int rlen);
      logic [7:0]  letters [3];
      logic [63:0] word;
      quiesce();
      foreach (letters[i]) letters[i] = 8'($urandom_range(255));
      for (int i = 0; i < MAX_PATTERN; i++) word[8*i +: 8] = letters[$urandom_range(2)];
      write_register(CSR_PATTERN_LENGTH, 64'(plen));
      write_register(CSR_PATTERN_BYTES, word);
      write_register(CSR_REPLACEMENT_LENGTH, 64'(rlen));
      write_register(CSR_REPLACEMENT_BYTES, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // one random string: whole and partial pattern copies, pattern letters, noise
   task automatic send_string(inout int sent);
      logic [7:0] text [$];
      int plen;
      int len;
      int pick;
      int cut;
      int lane;
      plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      len  = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      while (text.size() < len) begin
         pick = $urandom_range(99);
         if (plen != 0 && pick < 35) begin
            for (int i = 0; i < plen; i++) text.push_back(pat_word[8*i +: 8]);
         end else if (plen > 1 && pick < 55) begin
            cut = $urandom_range(1, plen - 1);
            for (int i = 0; i < cut; i++) text.push_back(pat_word[8*i +: 8]);
         end else if (plen != 0 && pick < 90) begin
            lane = $urandom_range(plen - 1);
            text.push_back(pat_word[8*lane +: 8]);
         end else begin
            text.push_back(8'($urandom_range(255)));
         end
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1, 1'b0, '0);
      sent += text.size();
   endtask

   // receiver: random stalls, or one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (edited_text_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result: data %h user %b last %b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want_rsp = edited_text_q.pop_front();
            if (rsp_tdata !== want_rsp.out_byte || rsp_tuser !== want_rsp.has_byte ||
                rsp_tlast !== want_rsp.string_done) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("mismatch: expected data %h user %b last %b, got data %h user %b last %b",
                           want_rsp.out_byte, want_rsp.has_byte, want_rsp.string_done,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      int sent;
      int new_plen;
      int new_rlen;
      bit paused;

      // directed table; 'a' 61, 'b' 62, 'c' 63, 'x' 78
      directed_rows = '{
         // pass through after reset, byte extremes
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b1, 8'h00}},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b1, 1'b1, 8'hFF}},
         // "abc" -> "XY"
         '{1'b1, CSR_PATTERN_LENGTH,     64'd3,        8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_PATTERN_BYTES,      64'h63_62_61, 8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_REPLACEMENT_LENGTH, 64'd2,        8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_REPLACEMENT_BYTES,  64'h59_58,    8'h00, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h62, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h63, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h78, 1'b1, 1'b1, '{1'b1, 1'b1, 8'h78}},
         // restart after a partial match: "aabc"
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h62, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h63, 1'b1, 1'b0, '0},
         // held prefix flushed at string end
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b1, 1'b1, '{1'b1, 1'b1, 8'h61}},
         // empty replacement deletes, bare end mark
         '{1'b1, CSR_REPLACEMENT_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h62, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h63, 1'b1, 1'b1, '{1'b1, 1'b0, 8'h00}},
         // oversized lengths clamp to eight
         '{1'b1, CSR_PATTERN_LENGTH,     64'd15,                  8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_PATTERN_BYTES,      64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_REPLACEMENT_LENGTH, 64'd15,                  8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_REPLACEMENT_BYTES,  64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b0, '0},
         // pattern changed while "ab" is held, then "bx" completes
         '{1'b1, CSR_PATTERN_LENGTH, 64'd3,        8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_PATTERN_BYTES,  64'h63_62_61, 8'h00, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h62, 1'b0, 1'b0, '0},
         '{1'b1, CSR_PATTERN_LENGTH, 64'd2,        8'h00, 1'b0, 1'b0, '0},
         '{1'b1, CSR_PATTERN_BYTES,  64'h78_62,    8'h00, 1'b0, 1'b0, '0},
         '{1'b0, CSR_PATTERN_LENGTH, 64'd0, 8'h78, 1'b1, 1'b0, '0}
      };

      // reset
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_reg) begin
            if (!csr_valid) quiesce();
            write_register(directed_rows[r].reg_idx, directed_rows[r].reg_val);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            push_byte(directed_rows[r].in_byte, directed_rows[r].eos,
                      directed_rows[r].typed, directed_rows[r].typed_rsp);
         end
      end

      // random phases with different settings and flow control mixes
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin new_plen = $urandom_range(1, 8); new_rlen = $urandom_range(0, 8); end
            1: begin new_plen = 8;  new_rlen = 8;  end
            2: begin new_plen = 1;  new_rlen = 0;  end
            3: begin new_plen = 15; new_rlen = 15; end
            4: begin new_plen = 2;  new_rlen = 8;  end
            5: begin new_plen = 0;  new_rlen = $urandom_range(0, 15); end
            default: begin
               new_plen = $urandom_range(0, 15);
               new_rlen = $urandom_range(0, 15);
            end
         endcase
         program_pattern(new_plen, new_rlen);
         case (phase % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 47; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 47; end
            default: begin send_gap_pct = 20; stall_pct = 20; end
         endcase
         // long receiver hold-off so the request queue backs up
         if (phase == PRESSURE_PHASE) hold_request = 1'b1;
         sent = 0;
         paused = 1'b0;
         while (sent < ITEMS_PER_PHASE) begin
            send_string(sent);
            // sender waits for every outstanding result once
            if (phase == PAUSE_PHASE && !paused && sent >= ITEMS_PER_PHASE / 2) begin
               paused = 1'b1;
               req_tvalid <= 1'b0;
               do @(posedge clock); while (edited_text_q.size() != 0);
            end
         end
      end

      // drain and report
      quiesce();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/ssr_pkg.sv
src/ssr_queue.sv
src/ssr_back.sv
src/stream_substring_replace_unit.sv
tb/stream_substring_replace_unit_tb.sv
